### rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix digit converter
// Constants, status types and small helper functions used by the converter,
// its serial divider and its top level.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_BITS_DEF = 31;

  localparam int BASE_W   = 6;
  localparam int DIGIT_W  = 6;
  localparam int CHAR_W   = 7;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;

  // Register word index of the base register.
  localparam logic [PADDR_W-1:0] REG_BASE = 2'd0;

  // Status of one finished division step sequence.
  typedef struct packed {
    logic               done;
    logic               nonzero;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_ALPHA + {1'b0, d} - {1'b0, DEC_LIMIT};
    end
    return c;
  endfunction

endpackage

### rtl/rdc_ram.sv
// ----------------------------------------------------------------------------
// rdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = rdc_pkg::DIGIT_W,
  parameter int DEPTH = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rdc_div.sv
// ----------------------------------------------------------------------------
// rdc_div: bit-serial restoring divider
// Divides a VALUE_BITS dividend by a small base, one quotient bit per cycle.
// The quotient stays in the shift register for the next pass.
// ----------------------------------------------------------------------------
module rdc_div #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [VALUE_BITS-1:0]     dividend,
  input  logic [rdc_pkg::BASE_W-1:0] base,
  output logic [VALUE_BITS-1:0]     quotient,
  output rdc_pkg::div_res_t         res
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]         sh;
  logic [VALUE_BITS-1:0]         sh_next;
  logic [rdc_pkg::DIGIT_W-1:0]   rem;
  logic [rdc_pkg::DIGIT_W-1:0]   rem_next;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;
  logic                          nz;
  logic [rdc_pkg::DIGIT_W:0]     trial;
  logic [rdc_pkg::DIGIT_W:0]     diff;
  logic                          ge;

  // Bring down the next dividend bit and try to subtract the base.
  always_comb begin
    trial    = {rem, sh[VALUE_BITS-1]};
    diff     = trial - {1'b0, base};
    ge       = (trial >= {1'b0, base});
    rem_next = ge ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
    sh_next  = {sh[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      sh   <= dividend;
      rem  <= '0;
      nz   <= 1'b0;
      cnt  <= CNT_W'(VALUE_BITS - 1);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      sh  <= sh_next;
      rem <= rem_next;
      nz  <= nz | ge;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient    = sh;
  assign res.done    = done;
  assign res.nonzero = nz;
  assign res.rem     = rem;

endmodule

### rtl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter: integer to base-N character string, bases 2 to 36
// Converts each input value to ASCII digits, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, value) takes one integer per beat.
//   Output channel (out_valid/out_ready, digit_char, last) gives one ASCII
//   digit per beat, most significant first; last marks the final digit.
//   A zero input gives the single character '0'.
//   The base register sits at byte address 0 of the APB port; values below
//   2 act as base 2 and values above 36 act as base 36. Reset sets base 10.
//   Each digit takes one pass of the bit-serial divider; the digits are
//   then read back from the digit RAM through a read state and a push
//   state per character. One item is worked on at a time.
//   The final character waits in the output register, so the next value is
//   taken while it is still pending. A stalled receiver holds the block in
//   its readback phase until the output register frees up.
//   Reset clears the control state and returns the base to ten.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [VALUE_BITS-1:0]        value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rdc_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [rdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [rdc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam int NUM_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  state_t                       state;
  logic [rdc_pkg::BASE_W-1:0]   base;
  logic [NUM_W-1:0]             num;
  logic [ADDR_W-1:0]            ptr;
  logic                         div_start;
  logic [VALUE_BITS-1:0]        div_dividend;
  logic [VALUE_BITS-1:0]        div_quot;
  rdc_pkg::div_res_t            div_res;
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [rdc_pkg::DIGIT_W-1:0]  ram_rd_data;
  logic                         out_free;
  logic                         push;
  logic                         cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = {{(rdc_pkg::PDATA_W - rdc_pkg::BASE_W){1'b0}}, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= rdc_pkg::BASE_RESET;
    end else if (cfg_write && (paddr == rdc_pkg::REG_BASE)) begin
      base <= pwdata[rdc_pkg::BASE_W-1:0];
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign push      = (state == ST_PUSH) && out_free;

  // A new value starts the first pass; a nonzero quotient starts the next.
  assign div_start    = (in_valid && in_ready) ||
                        ((state == ST_DIV) && div_res.done && div_res.nonzero);
  assign div_dividend = (state == ST_IDLE) ? value : div_quot;
  assign ram_wr_en    = (state == ST_DIV) && div_res.done;
  assign ram_rd_en    = (state == ST_READ);

  rdc_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .base     (rdc_pkg::eff_base(base)),
    .quotient (div_quot),
    .res      (div_res)
  );

  // Digits arrive least significant first and are read back in reverse.
  rdc_ram #(
    .WIDTH (rdc_pkg::DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (num[ADDR_W-1:0]),
    .wr_data (div_res.rem),
    .rd_en   (ram_rd_en),
    .rd_addr (ptr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      num       <= '0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            num   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            num <= num + 1'b1;
            if (!div_res.nonzero) begin
              ptr   <= num[ADDR_W-1:0];
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push) begin
            digit_char <= rdc_pkg::digit_ascii(ram_rd_data);
            last       <= (ptr == '0);
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A run never holds more digits than the value has bits.
  a_num_bound: assert property (@(posedge clk) disable iff (rst)
    num <= NUM_W'(VALUE_BITS))
    else $error("digit count exceeds value width");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("divider finished outside the division phase");

  a_wr_room: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (num < NUM_W'(VALUE_BITS)))
    else $error("digit write beyond RAM depth");

  a_push_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_PUSH))
    else $error("readback did not follow a RAM read");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the radix digit converter
// Integers are pushed through the input channel while the base register is
// stepped through ordinary and saturating settings over the APB port. Each
// accepted value is expanded here into its expected ASCII digits, and every
// output beat is checked against the oldest expected digit. Both channels
// idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_PRINTS  = 100;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] code;
    logic                       fin;
  } digit_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [VALUE_BITS-1:0]         value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [rdc_pkg::CHAR_W-1:0]    digit_char;
  logic                          last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rdc_pkg::PADDR_W-1:0]   paddr = '0;
  logic [rdc_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [rdc_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  logic [VALUE_BITS-1:0]         values_to_send[$];
  digit_beat_t                   digits_due[$];
  logic [rdc_pkg::BASE_W-1:0]    base_shadow = rdc_pkg::BASE_RESET;
  int                            mismatches = 0;
  int                            cycles = 0;
  logic                          hold_trigger = 1'b0;

  always #6 clk = ~clk;

  radix_digit_converter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: MISMATCH %s", $realtime, what);
    end
  endtask

  // Expands one value into its digits in the current base, most significant
  // digit first, and queues them as expected output beats.
  task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
    logic [rdc_pkg::BASE_W-1:0]  radix;
    logic [VALUE_BITS-1:0]       rest;
    logic [rdc_pkg::DIGIT_W-1:0] msd_first[$];
    digit_beat_t                 beat;
    radix = base_shadow;
    if (radix < rdc_pkg::BASE_MIN) begin
      radix = rdc_pkg::BASE_MIN;
    end else if (radix > rdc_pkg::BASE_MAX) begin
      radix = rdc_pkg::BASE_MAX;
    end
    rest = v;
    do begin
      msd_first.push_front(rdc_pkg::DIGIT_W'(rest % radix));
      rest = rest / radix;
    end while (rest != 0);
    foreach (msd_first[k]) begin
      if (msd_first[k] < rdc_pkg::DEC_LIMIT) begin
        beat.code = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(msd_first[k]);
      end else begin
        beat.code = rdc_pkg::CHAR_ALPHA +
                    rdc_pkg::CHAR_W'(msd_first[k] - rdc_pkg::DEC_LIMIT);
      end
      beat.fin = (k == msd_first.size() - 1);
      digits_due.push_back(beat);
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_value();
    logic [VALUE_BITS-1:0]      v;
    logic [rdc_pkg::BASE_W-1:0] radix;
    longint                     p;
    int                         bits;
    v = VALUE_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      1: begin
        bits = $urandom_range(1, VALUE_BITS);
        v = v & ((VALUE_BITS'(1) << bits) - 1);
      end
      2: begin
        v = VALUE_BITS'($urandom_range(0, 2000));
      end
      3: begin
        // Just around a power of the base, where the digit count steps.
        radix = base_shadow;
        if (radix < rdc_pkg::BASE_MIN) begin
          radix = rdc_pkg::BASE_MIN;
        end else if (radix > rdc_pkg::BASE_MAX) begin
          radix = rdc_pkg::BASE_MAX;
        end
        p = 1;
        repeat ($urandom_range(1, VALUE_BITS)) begin
          if (p * radix <= longint'(VALUE_MAX)) begin
            p = p * radix;
          end
        end
        v = VALUE_BITS'(p - 1 + $urandom_range(0, 2));
      end
      default: ;
    endcase
    return v;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // Beat still waiting; hold valid and payload.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (values_to_send.size() != 0) begin
      value <= values_to_send.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: runs of ready or stall of random length, plus one long hold.
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_trigger && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin : monitor
    digit_beat_t due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_digits(value);
      end
      if (out_valid && out_ready) begin
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: char %h last %b", digit_char, last));
        end else begin
          due = digits_due.pop_front();
          if (digit_char !== due.code) begin
            report_mismatch($sformatf("digit_char %h, expected %h", digit_char, due.code));
          end
          if (last !== due.fin) begin
            report_mismatch($sformatf("last %b, expected %b", last, due.fin));
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (values_to_send.size() != 0 || in_valid || digits_due.size() != 0);
  endtask

  // Waits until the sender and the block are drained, then writes the base.
  task automatic write_base(input logic [rdc_pkg::BASE_W-1:0] b);
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rdc_pkg::REG_BASE;
    pwdata <= rdc_pkg::PDATA_W'(b);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    base_shadow <= b;
    @(negedge clk);
  endtask

  task automatic offer(input logic [VALUE_BITS-1:0] v);
    values_to_send.push_back(v);
  endtask

  task automatic offer_random(input int count);
    repeat (count) begin
      values_to_send.push_back(rand_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset base of ten: zero, single digits, the digit rollover, extremes.
    offer('0);
    offer(VALUE_BITS'(1));
    offer(VALUE_BITS'(9));
    offer(VALUE_BITS'(10));
    offer(VALUE_MAX);
    offer(VALUE_BITS'(32'h5555_5555));
    offer(VALUE_BITS'(32'h2AAA_AAAA));
    offer_random(31);

    // Base two gives the longest runs.
    write_base(6'd2);
    offer(VALUE_BITS'(1));
    offer(VALUE_BITS'(1) << (VALUE_BITS - 1));
    offer(VALUE_MAX);
    offer_random(31);

    // Top base reaches the letter digits up to Z.
    write_base(rdc_pkg::BASE_MAX);
    offer(VALUE_BITS'(35));
    offer(VALUE_BITS'(36));
    offer(VALUE_BITS'(1295));
    offer(VALUE_BITS'(1296));
    offer(VALUE_MAX);
    offer_random(31);

    // Register values below two saturate to base two.
    write_base(6'd0);
    offer('0);
    offer(VALUE_BITS'(5));
    offer(VALUE_MAX);
    offer_random(20);

    write_base(6'd1);
    offer(VALUE_BITS'(2));
    offer(VALUE_BITS'(7));
    offer_random(20);

    // Register values above thirty-six saturate to base thirty-six.
    write_base(6'd37);
    offer(VALUE_BITS'(35));
    offer(VALUE_BITS'(36));
    offer_random(25);

    write_base(6'd63);
    offer(VALUE_BITS'(35));
    offer(VALUE_BITS'(36));
    offer_random(25);

    // The receiver holds off long enough for the input side to back up.
    write_base(6'd16);
    hold_trigger = 1'b1;
    offer_random(40);

    write_base(6'd7);
    offer_random(30);

    write_base(rdc_pkg::BASE_W'($urandom_range(0, 63)));
    offer_random(30);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/rdc_pkg.sv
rtl/rdc_ram.sv
rtl/rdc_div.sv
rtl/radix_digit_converter.sv
bench/tb.sv
